// ----- rtl/core/cycle_crossover_permutation_assert.svh -----
// Assertion macros for the cycle crossover block and its checker.
`ifndef CYCLE_CROSSOVER_PERMUTATION_ASSERT_SVH
`define CYCLE_CROSSOVER_PERMUTATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CXP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cycle crossover same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CXP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cycle crossover next-cycle check failed");

`endif

// ----- rtl/core/cxp_pkg.sv -----
// Shared constants and controller/datapath command and status types.
`default_nettype none
package cxp_pkg;

  localparam int DEF_MAX_POSITIONS = 64;
  localparam int DEF_ID_BITS       = 16;

  // Fixed field widths of the request and result channels
  localparam int FIELD_W  = 16;
  localparam int WEIGHT_W = 16;

  // Value shown for a child slot that no cycle filled
  localparam logic [FIELD_W-1:0] EMPTY_FIELD = '1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_we;      // store one position of both parents
    logic clear_flags;  // clear used and filled bits for a new run
    logic p1_re;        // read first parent at current position
    logic p2_re;        // read second parent at scan address
    logic wr_hit;       // matched: write both children, mark both used
    logic wr_miss;      // unmatched: write one child, mark first used
    logic parity;       // current cycle parity
    logic c_re;         // read both children at emit address
  } cxp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic p1_used_start;  // first parent used at start position
    logic p1_used_m;      // first parent used at scan position
    logic p2_hit;         // scan entry unused and ids equal
  } cxp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/cxp_if.sv -----
// Valid/ready channel interfaces for parent requests and child results.
`default_nettype none
interface cxp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_id;
  logic [15:0] first_weight;
  logic [15:0] second_id;
  logic [15:0] second_weight;
  logic        final_position;

  modport source (output valid, first_id, first_weight, second_id, second_weight,
                  final_position, input ready);
  modport sink   (input valid, first_id, first_weight, second_id, second_weight,
                  final_position, output ready);
endinterface

interface cxp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] child_one_id;
  logic [15:0] child_one_weight;
  logic [15:0] child_two_id;
  logic [15:0] child_two_weight;
  logic        mismatch;
  logic        final_output;

  modport source (output valid, child_one_id, child_one_weight, child_two_id,
                  child_two_weight, mismatch, final_output, input ready);
  modport sink   (input valid, child_one_id, child_one_weight, child_two_id,
                  child_two_weight, mismatch, final_output, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cxp_dp.sv -----
// Datapath: parent and child memories, used/filled bits, id compare.
`default_nettype none
module cxp_dp #(
  parameter int MAX_POSITIONS = cxp_pkg::DEF_MAX_POSITIONS,
  parameter int ID_BITS       = cxp_pkg::DEF_ID_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cxp_pkg::cxp_cmd_t                     cmd,
  output cxp_pkg::cxp_stat_t                    stat,
  input  logic [$clog2(MAX_POSITIONS)-1:0]      load_idx,
  input  logic [$clog2(MAX_POSITIONS)-1:0]      pos_idx,
  input  logic [$clog2(MAX_POSITIONS)-1:0]      m_idx,
  input  logic [$clog2(MAX_POSITIONS)-1:0]      scan_idx,
  input  logic [$clog2(MAX_POSITIONS)-1:0]      start_idx,
  input  logic [$clog2(MAX_POSITIONS)-1:0]      emit_idx,
  input  logic [cxp_pkg::FIELD_W-1:0]           first_id,
  input  logic [cxp_pkg::WEIGHT_W-1:0]          first_weight,
  input  logic [cxp_pkg::FIELD_W-1:0]           second_id,
  input  logic [cxp_pkg::WEIGHT_W-1:0]          second_weight,
  output logic [cxp_pkg::FIELD_W-1:0]           child_one_id,
  output logic [cxp_pkg::WEIGHT_W-1:0]          child_one_weight,
  output logic [cxp_pkg::FIELD_W-1:0]           child_two_id,
  output logic [cxp_pkg::WEIGHT_W-1:0]          child_two_weight
);
  import cxp_pkg::*;

  localparam int IDX_W = $clog2(MAX_POSITIONS);
  // Ids are kept in their low ID_BITS bits, never more than the field width
  localparam int ID_W  = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;
  localparam int ENT_W = ID_W + WEIGHT_W;

  // Entries hold {weight, id}
  logic [ENT_W-1:0] p1_mem [MAX_POSITIONS];
  logic [ENT_W-1:0] p2_mem [MAX_POSITIONS];
  logic [ENT_W-1:0] c1_mem [MAX_POSITIONS];
  logic [ENT_W-1:0] c2_mem [MAX_POSITIONS];

  logic [ENT_W-1:0] p1_rd_r, p2_rd_r, c1_rd_r, c2_rd_r;
  logic             c1_ok_r, c2_ok_r;

  logic [MAX_POSITIONS-1:0] p1_used_r, p2_used_r, c1_fill_r, c2_fill_r;

  logic             c1_we, c2_we;
  logic [IDX_W-1:0] c1_addr, c2_addr;
  logic [ENT_W-1:0] c1_data, c2_data;

  // Child write steering: parity picks which child copies which parent
  always_comb begin
    c1_we   = cmd.wr_hit || (cmd.wr_miss && !cmd.parity);
    c2_we   = cmd.wr_hit || (cmd.wr_miss && cmd.parity);
    c1_addr = (cmd.wr_hit && cmd.parity) ? m_idx : pos_idx;
    c1_data = (cmd.wr_hit && cmd.parity) ? p2_rd_r : p1_rd_r;
    c2_addr = (cmd.wr_hit && !cmd.parity) ? m_idx : pos_idx;
    c2_data = (cmd.wr_hit && !cmd.parity) ? p2_rd_r : p1_rd_r;
  end

  // Parent stores: written on load, read one port each during the walk
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      p1_mem[load_idx] <= {first_weight, first_id[ID_W-1:0]};
      p2_mem[load_idx] <= {second_weight, second_id[ID_W-1:0]};
    end
    if (cmd.p1_re) begin
      p1_rd_r <= p1_mem[pos_idx];
    end
    if (cmd.p2_re) begin
      p2_rd_r <= p2_mem[scan_idx];
    end
  end

  // Child stores and registered emission read
  always_ff @(posedge clk) begin
    if (c1_we) begin
      c1_mem[c1_addr] <= c1_data;
    end
    if (c2_we) begin
      c2_mem[c2_addr] <= c2_data;
    end
    if (cmd.c_re) begin
      c1_rd_r <= c1_mem[emit_idx];
      c2_rd_r <= c2_mem[emit_idx];
      c1_ok_r <= c1_fill_r[emit_idx];
      c2_ok_r <= c2_fill_r[emit_idx];
    end
  end

  // Used and filled bits, cleared at reset and at the start of every run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_used_r <= '0;
      p2_used_r <= '0;
      c1_fill_r <= '0;
      c2_fill_r <= '0;
    end else if (cmd.clear_flags) begin
      p1_used_r <= '0;
      p2_used_r <= '0;
      c1_fill_r <= '0;
      c2_fill_r <= '0;
    end else begin
      if (cmd.wr_hit || cmd.wr_miss) begin
        p1_used_r[pos_idx] <= 1'b1;
      end
      if (cmd.wr_hit) begin
        p2_used_r[m_idx] <= 1'b1;
      end
      if (c1_we) begin
        c1_fill_r[c1_addr] <= 1'b1;
      end
      if (c2_we) begin
        c2_fill_r[c2_addr] <= 1'b1;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    stat.p1_used_start = p1_used_r[start_idx];
    stat.p1_used_m     = p1_used_r[m_idx];
    stat.p2_hit        = !p2_used_r[m_idx] && (p2_rd_r[ID_W-1:0] == p1_rd_r[ID_W-1:0]);
  end

  // Result fields; unfilled slots read as all ones
  assign child_one_id     = c1_ok_r ? FIELD_W'(c1_rd_r[ID_W-1:0]) : EMPTY_FIELD;
  assign child_one_weight = c1_ok_r ? c1_rd_r[ENT_W-1:ID_W] : EMPTY_FIELD;
  assign child_two_id     = c2_ok_r ? FIELD_W'(c2_rd_r[ID_W-1:0]) : EMPTY_FIELD;
  assign child_two_weight = c2_ok_r ? c2_rd_r[ENT_W-1:ID_W] : EMPTY_FIELD;

endmodule
`default_nettype wire

// ----- rtl/core/cxp_ctrl.sv -----
// Controller: load counting, cycle walk sequencing and result emission.
`default_nettype none
module cxp_ctrl #(
  parameter int MAX_POSITIONS = cxp_pkg::DEF_MAX_POSITIONS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_final,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_final,
  output logic                                  out_mismatch,
  output cxp_pkg::cxp_cmd_t                     cmd,
  input  cxp_pkg::cxp_stat_t                    stat,
  output logic [$clog2(MAX_POSITIONS)-1:0]      load_idx,
  output logic [$clog2(MAX_POSITIONS)-1:0]      pos_idx,
  output logic [$clog2(MAX_POSITIONS)-1:0]      m_idx,
  output logic [$clog2(MAX_POSITIONS)-1:0]      scan_idx,
  output logic [$clog2(MAX_POSITIONS)-1:0]      start_idx,
  output logic [$clog2(MAX_POSITIONS)-1:0]      emit_idx
);
  import cxp_pkg::*;

  localparam int IDX_W = $clog2(MAX_POSITIONS);
  localparam int CNT_W = $clog2(MAX_POSITIONS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_READ,
    ST_SCAN,
    ST_EM_RD,
    ST_EM_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] m_r, m_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             parity_r, parity_nxt;
  logic             bad_r, bad_nxt;
  logic             in_ready_r, in_ready_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             final_r, final_nxt;

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] n_last;

  assign in_acc = in_valid && in_ready_r;
  assign out_acc = out_valid_r && out_ready;
  assign n_last = n_r - CNT_W'(1);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    parity_nxt    = parity_r;
    bad_nxt       = bad_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    final_nxt     = final_r;
    cmd           = '0;
    cmd.parity    = parity_r;

    case (state_r)
      // Store positions; the final request starts the walk
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_POSITIONS)) begin
            cmd.load_we = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
          end
          if (in_final) begin
            n_nxt           = count_nxt;
            cmd.clear_flags = 1'b1;
            parity_nxt      = 1'b0;
            bad_nxt         = 1'b0;
            start_nxt       = '0;
            in_ready_nxt    = 1'b0;
            state_nxt       = ST_START;
          end
        end
      end
      // Find the lowest first-parent position not yet used
      ST_START: begin
        if (start_r == n_r) begin
          k_nxt     = '0;
          state_nxt = ST_EM_RD;
        end else if (stat.p1_used_start) begin
          start_nxt = start_r + CNT_W'(1);
        end else begin
          pos_nxt   = start_r[IDX_W-1:0];
          state_nxt = ST_READ;
        end
      end
      // Fetch first parent at pos and second parent at position zero
      ST_READ: begin
        cmd.p1_re = 1'b1;
        cmd.p2_re = 1'b1;
        m_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      // Linear search of the second parent, one entry per cycle
      ST_SCAN: begin
        cmd.p2_re = 1'b1;
        if (stat.p2_hit) begin
          cmd.wr_hit = 1'b1;
          pos_nxt    = m_r;
          if (stat.p1_used_m || (m_r == pos_r)) begin
            parity_nxt = ~parity_r;
            start_nxt  = start_r + CNT_W'(1);
            state_nxt  = ST_START;
          end else begin
            state_nxt = ST_READ;
          end
        end else if (CNT_W'(m_r) == n_last) begin
          // No unused match: cycle closes with a mismatch
          cmd.wr_miss = 1'b1;
          bad_nxt     = 1'b1;
          parity_nxt  = ~parity_r;
          start_nxt   = start_r + CNT_W'(1);
          state_nxt   = ST_START;
        end else begin
          m_nxt = m_r + IDX_W'(1);
        end
      end
      // Read both children at position k
      ST_EM_RD: begin
        cmd.c_re      = 1'b1;
        final_nxt     = (CNT_W'(k_r) == n_last);
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EM_OUT;
      end
      // Hold the result until taken
      ST_EM_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (final_r) begin
            count_nxt    = '0;
            in_ready_nxt = 1'b1;
            state_nxt    = ST_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      n_r         <= '0;
      start_r     <= '0;
      pos_r       <= '0;
      m_r         <= '0;
      k_r         <= '0;
      parity_r    <= 1'b0;
      bad_r       <= 1'b0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
      m_r         <= m_nxt;
      k_r         <= k_nxt;
      parity_r    <= parity_nxt;
      bad_r       <= bad_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
    end
  end

  // Addresses to the datapath
  assign load_idx  = count_r[IDX_W-1:0];
  assign pos_idx   = pos_r;
  assign m_idx     = m_r;
  assign scan_idx  = (state_r == ST_READ) ? '0 : (m_r + IDX_W'(1));
  assign start_idx = start_r[IDX_W-1:0];
  assign emit_idx  = k_r;

  assign in_ready     = in_ready_r;
  assign out_valid    = out_valid_r;
  assign out_final    = final_r;
  assign out_mismatch = bad_r;

endmodule
`default_nettype wire

// ----- rtl/core/cycle_crossover_permutation.sv -----
// Top level of the cycle crossover block: controller plus datapath.
//
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          first_id/weight, second_id/weight, final_position
//  out_ch   out  valid/ready          child_one/two id and weight, mismatch, final_output
//
// Loading accepts positions back to back; the walk starts on the final request.
// Walk: per position a start search step, a read and a scan of up to n entries
// on the single second-parent read port. Emission: each result passes a child
// memory read, then the output register, and is held while the sink stalls. No
// requests are taken from the final one until the last result is taken. Reset
// clears all flags.
`default_nettype none
module cycle_crossover_permutation #(
  parameter int MAX_POSITIONS = cxp_pkg::DEF_MAX_POSITIONS,
  parameter int ID_BITS       = cxp_pkg::DEF_ID_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  cxp_in_if.sink    in_ch,
  cxp_out_if.source out_ch
);
  import cxp_pkg::*;

  localparam int IDX_W = $clog2(MAX_POSITIONS);

  cxp_cmd_t         cmd;
  cxp_stat_t        stat;
  logic [IDX_W-1:0] load_idx, pos_idx, m_idx, scan_idx, start_idx, emit_idx;

  // Sequencer
  cxp_ctrl #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_final    (in_ch.final_position),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_final   (out_ch.final_output),
    .out_mismatch(out_ch.mismatch),
    .cmd         (cmd),
    .stat        (stat),
    .load_idx    (load_idx),
    .pos_idx     (pos_idx),
    .m_idx       (m_idx),
    .scan_idx    (scan_idx),
    .start_idx   (start_idx),
    .emit_idx    (emit_idx)
  );

  // Storage and compare
  cxp_dp #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .load_idx        (load_idx),
    .pos_idx         (pos_idx),
    .m_idx           (m_idx),
    .scan_idx        (scan_idx),
    .start_idx       (start_idx),
    .emit_idx        (emit_idx),
    .first_id        (in_ch.first_id),
    .first_weight    (in_ch.first_weight),
    .second_id       (in_ch.second_id),
    .second_weight   (in_ch.second_weight),
    .child_one_id    (out_ch.child_one_id),
    .child_one_weight(out_ch.child_one_weight),
    .child_two_id    (out_ch.child_two_id),
    .child_two_weight(out_ch.child_two_weight)
  );

endmodule
`default_nettype wire

// ----- rtl/core/cxp_checker.sv -----
// Port-level checker for the cycle crossover block and its bind.
`default_nettype none
`include "cycle_crossover_permutation_assert.svh"
module cxp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] c1_id,
  input logic [15:0] c1_weight,
  input logic [15:0] c2_id,
  input logic [15:0] c2_weight,
  input logic        out_mismatch,
  input logic        out_final
);

  // Requests are never taken while results are pending
  `CXP_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, !in_ready)

  // The final request closes the request side
  `CXP_ASSERT_NEXT(a_final_closes, clk, rst_n, in_valid && in_ready && in_final, !in_ready)

  // Taking the last result ends the run's output
  `CXP_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && out_final, !out_valid)

  // A stalled result holds its payload
  `CXP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({c1_id, c1_weight, c2_id, c2_weight, out_mismatch, out_final}))

endmodule

bind cycle_crossover_permutation cxp_checker u_cxp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_final    (in_ch.final_position),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .c1_id       (out_ch.child_one_id),
  .c1_weight   (out_ch.child_one_weight),
  .c2_id       (out_ch.child_two_id),
  .c2_weight   (out_ch.child_two_weight),
  .out_mismatch(out_ch.mismatch),
  .out_final   (out_ch.final_output)
);
`default_nettype wire
